// ===== rtl/core/agr_pkg.sv =====
// Shared types, constants and helper functions of the audio gain ramp unit.
`default_nettype none

package agr_pkg;

  localparam int unsigned MaxFrameSamples = 1024;
  localparam int unsigned MaxChannels     = 8;

  localparam int unsigned PosW = (MaxFrameSamples > 1) ? $clog2(MaxFrameSamples) : 1;
  localparam int unsigned ChW  = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  // position compares run at this width, wide enough for every count in range
  localparam int unsigned CmpW = 16;

  localparam int unsigned GainW   = 20;
  localparam int unsigned StepW   = 24;
  localparam int unsigned SampleW = 24;
  localparam int unsigned FsW     = 11;
  localparam int unsigned RecipW  = 17;
  localparam int unsigned CcW     = 4;
  localparam int unsigned ProdW   = SampleW + GainW + 1;
  localparam int unsigned SumW    = StepW + 1;

  localparam logic [GainW-1:0] GainUnity = GainW'(65536);
  localparam logic [GainW-1:0] GainMax   = GainW'(1048575);

  localparam logic [FsW-1:0]    FrameSamplesRst = FsW'(160);
  localparam logic [RecipW-1:0] FrameRecipRst   = RecipW'(410);
  localparam logic [CcW-1:0]    ChannelCountRst = CcW'(1);

  // -32768.0 and 32767.0 in Q16.8
  localparam logic signed [SampleW-1:0] OutMin = SampleW'(-8388608);
  localparam logic signed [SampleW-1:0] OutMax = SampleW'(8388352);

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    RegTargetGain   = 2'd0,
    RegFrameSamples = 2'd1,
    RegFrameRecip   = 2'd2,
    RegChannelCount = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [GainW-1:0]  target_gain;
    logic [FsW-1:0]    frame_samples;
    logic [RecipW-1:0] frame_recip;
    logic [CcW-1:0]    channel_count;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [GainW-1:0]          gain;
    logic                      bypass;
    logic                      frame_end;
  } gain_beat_t;

  // Signed ramp step: sign(d) * ((|d| * recip + 0.5) >> 16), d = target - prev.
  function automatic logic signed [StepW-1:0] ramp_step_f(
    input logic [GainW-1:0]  target,
    input logic [GainW-1:0]  prev,
    input logic [RecipW-1:0] recip
  );
    logic signed [GainW:0]     diff;
    logic [GainW-1:0]          mag;
    logic [GainW+RecipW:0]     prod;
    logic [GainW+RecipW-16:0]  quo;
    logic signed [StepW-1:0]   step;
    diff = $signed({1'b0, target}) - $signed({1'b0, prev});
    mag  = diff[GainW] ? GainW'(0) - diff[GainW-1:0] : diff[GainW-1:0];
    prod = (GainW+RecipW+1)'(mag) * (GainW+RecipW+1)'(recip)
         + (GainW+RecipW+1)'(32768);
    quo  = prod[GainW+RecipW:16];
    step = StepW'(quo);
    return diff[GainW] ? -step : step;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/agr_cfg.sv =====
// APB register file holding the gain ramp configuration.
`default_nettype none

module agr_cfg import agr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegTargetGain:   cfg_d.target_gain   = pwdata[GainW-1:0];
        RegFrameSamples: cfg_d.frame_samples = pwdata[FsW-1:0];
        RegFrameRecip:   cfg_d.frame_recip   = pwdata[RecipW-1:0];
        RegChannelCount: cfg_d.channel_count = pwdata[CcW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegTargetGain:   prdata = DataW'(cfg_q.target_gain);
      RegFrameSamples: prdata = DataW'(cfg_q.frame_samples);
      RegFrameRecip:   prdata = DataW'(cfg_q.frame_recip);
      RegChannelCount: prdata = DataW'(cfg_q.channel_count);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_gain   <= GainUnity;
      cfg_q.frame_samples <= FrameSamplesRst;
      cfg_q.frame_recip   <= FrameRecipRst;
      cfg_q.channel_count <= ChannelCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/agr_gain_ctrl.sv =====
// Input register, frame/channel counters and per-sample ramp gain.
`default_nettype none

module agr_gain_ctrl import agr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [SampleW-1:0] in_sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output gain_beat_t              out_beat_o
);

  // input stage
  logic                      v0_q, v0_d;
  logic signed [SampleW-1:0] s0_q;
  // gain stage
  logic       v1_q, v1_d;
  gain_beat_t b1_q, b1_d;

  // ramp state
  logic [GainW-1:0]        prev_q, prev_d;
  logic [GainW-1:0]        run_q, run_d;
  logic signed [StepW-1:0] step_q, step_d;
  logic signed [StepW-1:0] cand_q, cand_d;
  logic [PosW-1:0]         sp_q, sp_d;
  logic [ChW-1:0]          cp_q, cp_d;

  logic adv0, adv1, fire1;
  logic [CmpW-1:0] len, chs, sp_next, cp_next;
  logic chan_end, frame_end;
  logic signed [StepW-1:0] step_use;
  logic [GainW-1:0] base, gain;
  logic signed [SumW-1:0] sum, tgt_s, lim;
  logic tgt_up, tgt_down;

  assign adv1       = !v1_q || out_ready_i;
  assign adv0       = !v0_q || adv1;
  assign fire1      = v0_q && adv1;
  assign in_ready_o = adv0;

  always_comb begin
    if (cfg_i.frame_samples == '0) begin
      len = CmpW'(1);
    end else if (CmpW'(cfg_i.frame_samples) > CmpW'(MaxFrameSamples)) begin
      len = CmpW'(MaxFrameSamples);
    end else begin
      len = CmpW'(cfg_i.frame_samples);
    end
    if (cfg_i.channel_count == '0) begin
      chs = CmpW'(1);
    end else if (CmpW'(cfg_i.channel_count) > CmpW'(MaxChannels)) begin
      chs = CmpW'(MaxChannels);
    end else begin
      chs = CmpW'(cfg_i.channel_count);
    end
  end

  assign sp_next   = CmpW'(sp_q) + CmpW'(1);
  assign cp_next   = CmpW'(cp_q) + CmpW'(1);
  assign chan_end  = sp_next >= len;
  assign frame_end = chan_end && (cp_next >= chs);

  // frame start takes the step prepared from the latest target and previous gain
  assign step_use = (sp_q == '0 && cp_q == '0) ? cand_q : step_q;
  assign base     = (sp_q == '0) ? prev_q : run_q;
  assign tgt_up   = cfg_i.target_gain > prev_q;
  assign tgt_down = cfg_i.target_gain < prev_q;
  assign tgt_s    = $signed(SumW'(cfg_i.target_gain));
  assign sum      = $signed(SumW'(base)) + SumW'(step_use);

  always_comb begin
    if (tgt_up) begin
      lim = (sum > tgt_s) ? tgt_s : sum;
    end else if (tgt_down) begin
      lim = (sum < tgt_s) ? tgt_s : sum;
    end else begin
      lim = tgt_s;
    end
    if (lim < 0) begin
      gain = '0;
    end else if (lim > $signed(SumW'(GainMax))) begin
      gain = GainMax;
    end else begin
      gain = lim[GainW-1:0];
    end
  end

  always_comb begin
    v0_d   = v0_q;
    v1_d   = v1_q;
    b1_d   = b1_q;
    prev_d = prev_q;
    run_d  = run_q;
    step_d = step_q;
    sp_d   = sp_q;
    cp_d   = cp_q;
    if (adv0) begin
      v0_d = in_valid_i;
    end
    if (adv1) begin
      v1_d = v0_q;
    end
    if (fire1) begin
      b1_d.sample    = s0_q;
      b1_d.gain      = gain;
      b1_d.bypass    = (cfg_i.target_gain == GainUnity) && (prev_q == GainUnity);
      b1_d.frame_end = frame_end;
      run_d  = gain;
      step_d = step_use;
      if (chan_end) begin
        sp_d = '0;
        if (frame_end) begin
          cp_d   = '0;
          prev_d = cfg_i.target_gain;
        end else begin
          cp_d = cp_q + ChW'(1);
        end
      end else begin
        sp_d = sp_q + PosW'(1);
      end
    end
    // register the next frame's step ahead of its first sample
    cand_d = ramp_step_f(cfg_i.target_gain, prev_d, cfg_i.frame_recip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      prev_q <= GainUnity;
      run_q  <= GainUnity;
      step_q <= '0;
      cand_q <= '0;
      sp_q   <= '0;
      cp_q   <= '0;
    end else begin
      v0_q   <= v0_d;
      v1_q   <= v1_d;
      prev_q <= prev_d;
      run_q  <= run_d;
      step_q <= step_d;
      cand_q <= cand_d;
      sp_q   <= sp_d;
      cp_q   <= cp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0 && in_valid_i) begin
      s0_q <= in_sample_i;
    end
    b1_q <= b1_d;
  end

  assign out_valid_o = v1_q;
  assign out_beat_o  = b1_q;

  a_frame_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire1 && frame_end |=> sp_q == '0 && cp_q == '0)
    else $error("counters did not wrap at frame end");

  a_frame_end_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire1 && frame_end |=> prev_q == $past(cfg_i.target_gain))
    else $error("previous gain not updated at frame end");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v0_q |-> in_ready_o)
    else $error("empty input stage refuses a beat");

endmodule

`default_nettype wire

// ===== rtl/core/agr_scale.sv =====
// Sample times gain, then rounding and saturation into the result register.
`default_nettype none

module agr_scale import agr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire gain_beat_t         in_beat_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [SampleW-1:0]      out_sample_o,
  output logic                    out_last_o
);

  logic v2_q, v3_q;
  logic adv2, adv3;

  logic signed [ProdW-1:0]   prod_q;
  logic signed [SampleW-1:0] smp2_q;
  logic                      byp2_q, fe2_q;

  logic signed [SampleW-1:0] res3_q, res3_d;
  logic                      fe3_q;
  logic                      byp3_q;

  logic signed [ProdW:0]    biased;
  logic signed [ProdW-16:0] rnd;

  assign adv3       = !v3_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign in_ready_o = adv2;

  // floor((p + 0.5) >> 16) via arithmetic shift
  assign biased = (ProdW+1)'(prod_q) + (ProdW+1)'(32768);
  assign rnd    = biased[ProdW:16];

  always_comb begin
    if (byp2_q) begin
      res3_d = smp2_q;
    end else if (rnd < $signed((ProdW-15)'(OutMin))) begin
      res3_d = OutMin;
    end else if (rnd > $signed((ProdW-15)'(OutMax))) begin
      res3_d = OutMax;
    end else begin
      res3_d = rnd[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv2) begin
        v2_q <= in_valid_i;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && in_valid_i) begin
      prod_q <= ProdW'(in_beat_i.sample) * ProdW'($signed({1'b0, in_beat_i.gain}));
      smp2_q <= in_beat_i.sample;
      byp2_q <= in_beat_i.bypass;
      fe2_q  <= in_beat_i.frame_end;
    end
    if (adv3 && v2_q) begin
      res3_q <= res3_d;
      byp3_q <= byp2_q;
      fe3_q  <= fe2_q;
    end
  end

  assign out_valid_o  = v3_q;
  assign out_sample_o = res3_q;
  assign out_last_o   = fe3_q;

  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !byp3_q |-> res3_q >= OutMin && res3_q <= OutMax)
    else $error("saturated sample out of range");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && adv3 |=> v3_q)
    else $error("product stage beat lost");

endmodule

`default_nettype wire

// ===== rtl/core/audio_gain_ramp_saturate_unit.sv =====
// Top level of the audio gain ramp and saturation unit.
`default_nettype none

// Scales a stream of Q16.8 samples, channel-major within each frame, by a gain
// that ramps linearly from the previous frame's gain to target_gain within each
// channel's part of the frame, then rounds and saturates to -32768.0..32767.0.
// One sample is accepted per clock while the output does not stall; each result
// passes the input register, gain stage, multiplier stage and result register
// in that order, and stalls hold the pipeline in place. The ramp gain is the
// only loop and is one add and compare a sample. Write registers only while the
// stream is idle; tlast marks the last sample of the last channel of a frame.
// Unity gain that is steady passes samples through unclamped.
module audio_gain_ramp_saturate_unit import agr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // APB configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [DataW-1:0]   pwdata,
  output logic      [DataW-1:0]   prdata,
  output logic                    pready,
  // input samples
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [SampleW-1:0] s_axis_tdata,   // [23:0] sample_in
  // scaled samples
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [SampleW-1:0]      m_axis_tdata,   // [23:0] sample_out
  output logic                    m_axis_tlast    // frame_end
);

  cfg_t       cfg;
  logic       g_valid, g_ready;
  gain_beat_t g_beat;

  agr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  agr_gain_ctrl u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata),
    .out_valid_o (g_valid),
    .out_ready_i (g_ready),
    .out_beat_o  (g_beat)
  );

  agr_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (g_valid),
    .in_ready_o   (g_ready),
    .in_beat_i    (g_beat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the audio gain ramp and saturation unit.
module tb;
  import agr_pkg::*;

  localparam int unsigned ItemTarget = 1425;
  localparam int unsigned MaxReports = 200;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last;
  } scaled_beat_t;

  typedef enum int {RxOpen, RxCoin, RxSparse, RxAlternate, RxHold} rx_mode_e;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [DataW-1:0]   pwdata = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [SampleW-1:0] s_axis_tdata = '0;   // [23:0] sample_in
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [SampleW-1:0] m_axis_tdata;        // [23:0] sample_out
  logic               m_axis_tlast;

  // gain model state and register copies
  logic [GainW-1:0]  cur_target;
  logic [FsW-1:0]    cur_frame_samples;
  logic [RecipW-1:0] cur_recip;
  logic [CcW-1:0]    cur_channels;
  longint            prev_gain;
  longint            live_gain;
  longint            ramp_inc;
  longint            sample_idx;
  longint            channel_idx;

  scaled_beat_t scaled_fifo[$];
  scaled_beat_t want;
  int unsigned  fail_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  burst_left = 0;
  rx_mode_e     rx_mode = RxOpen;
  int unsigned  rx_left = 0;

  audio_gain_ramp_saturate_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [DataW-1:0] reg_mask(input reg_idx_e idx);
    case (idx)
      RegTargetGain:   return (32'd1 << GainW) - 1;
      RegFrameSamples: return (32'd1 << FsW) - 1;
      RegFrameRecip:   return (32'd1 << RecipW) - 1;
      default:         return (32'd1 << CcW) - 1;
    endcase
  endfunction

  // Now and then set random bits above the register width; the block must drop them.
  function automatic logic [DataW-1:0] with_junk(input reg_idx_e idx, input logic [DataW-1:0] v);
    if ($urandom_range(0, 3) != 0) return v;
    return v | ($urandom() & ~reg_mask(idx));
  endfunction

  function automatic longint ramp_increment(input longint diff);
    longint mag;
    longint stp;
    mag = (diff < 0) ? -diff : diff;
    stp = (mag * longint'(cur_recip) + 32768) >>> 16;
    return (diff < 0) ? -stp : stp;
  endfunction

  function automatic void apply_gain_ramp(input logic [SampleW-1:0] din);
    longint len;
    longint chs;
    longint smp;
    longint tgt;
    longint g;
    longint res;
    scaled_beat_t beat;
    len = longint'(cur_frame_samples);
    if (len < 1) len = 1;
    if (len > longint'(MaxFrameSamples)) len = longint'(MaxFrameSamples);
    chs = longint'(cur_channels);
    if (chs < 1) chs = 1;
    if (chs > longint'(MaxChannels)) chs = longint'(MaxChannels);
    smp = longint'($signed(din));
    tgt = longint'(cur_target);

    if (sample_idx == 0 && channel_idx == 0) ramp_inc = ramp_increment(tgt - prev_gain);
    if (sample_idx == 0) live_gain = prev_gain;

    // direction follows the current target even if it moved mid-frame
    if (tgt > prev_gain) begin
      g = live_gain + ramp_inc;
      if (g > tgt) g = tgt;
    end else if (tgt < prev_gain) begin
      g = live_gain + ramp_inc;
      if (g < tgt) g = tgt;
    end else begin
      g = tgt;
    end
    if (g < 0) g = 0;
    if (g > longint'(GainMax)) g = longint'(GainMax);
    live_gain = g;

    if (tgt == longint'(GainUnity) && prev_gain == tgt) begin
      res = smp;
    end else begin
      res = (smp * g + 32768) >>> 16;
      if (res < longint'(OutMin)) res = longint'(OutMin);
      if (res > longint'(OutMax)) res = longint'(OutMax);
    end

    beat.last = 1'b0;
    if (sample_idx + 1 >= len) begin
      sample_idx = 0;
      if (channel_idx + 1 >= chs) begin
        channel_idx = 0;
        beat.last = 1'b1;
        prev_gain = tgt;
      end else begin
        channel_idx++;
      end
    end else begin
      sample_idx++;
    end
    beat.sample = res[SampleW-1:0];
    scaled_fifo.push_back(beat);
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return SampleW'($urandom_range(0, 1023)) - SampleW'(512);
      3:       return SampleW'($urandom_range(32760 * 256, 32776 * 256));
      default: return SampleW'($urandom());
    endcase
  endfunction

  // Drop tvalid and wait for every pending sample to come back.
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (scaled_fifo.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [SampleW-1:0] din);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= din;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_gain_ramp(din);
    items_sent++;
  endtask

  // Write a register, then read it back in the following transfer.
  task automatic cfg_write(input reg_idx_e idx, input logic [DataW-1:0] value);
    drain_stream();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegTargetGain:   cur_target = GainW'(value);
      RegFrameSamples: cur_frame_samples = FsW'(value);
      RegFrameRecip:   cur_recip = RecipW'(value);
      default:         cur_channels = CcW'(value);
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (value & reg_mask(idx))) begin
      fail_count++;
      $error("%s: expected %0h, actual %0h", idx.name(), value & reg_mask(idx), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_unity_bypass();
    cfg_write(RegFrameSamples, 32'd2);
    cfg_write(RegFrameRecip, 32'd32768);
    cfg_write(RegChannelCount, 32'd1);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000001);
    send_sample(24'hFFFFFF);
  endtask

  task automatic test_ramp_extremes();
    cfg_write(RegTargetGain, 32'(GainMax));
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    send_sample(24'h000100);
    cfg_write(RegTargetGain, 32'd0);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
  endtask

  // A step that rounds to nothing holds the previous gain for the frame.
  task automatic test_zero_step();
    cfg_write(RegFrameRecip, 32'd1);
    cfg_write(RegTargetGain, 32'd1);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
  endtask

  task automatic test_length_limits();
    cfg_write(RegFrameSamples, 32'd0);
    cfg_write(RegChannelCount, 32'd0);
    cfg_write(RegTargetGain, 32'(GainUnity));
    send_sample(24'h123456);
    send_sample(24'h800000);
    cfg_write(RegFrameSamples, 32'd2047);
    cfg_write(RegChannelCount, 32'd15);
    cfg_write(RegFrameRecip, 32'd131071);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000080);
  endtask

  // Shrink lengths past the current position and flip the target mid-frame.
  task automatic test_midframe_changes();
    cfg_write(RegFrameSamples, 32'd2);
    send_sample(24'h7FFFFF);
    cfg_write(RegChannelCount, 32'd1);
    send_sample(24'h400000);
    send_sample(24'hC00000);
    cfg_write(RegTargetGain, 32'd0);
    send_sample(24'h7FFFFF);
    cfg_write(RegTargetGain, 32'(GainMax));
    send_sample(24'h7FFFFF);
    cfg_write(RegTargetGain, 32'h80000);
    send_sample(24'h001000);
    send_sample(24'hFFF000);
    cfg_write(RegTargetGain, 32'(GainMax));
    send_sample(24'h000800);
    cfg_write(RegTargetGain, 32'd1);
    send_sample(24'h000800);
  endtask

  task automatic test_random_traffic();
    logic [DataW-1:0] v;
    longint fs_eff;
    longint cc_eff;
    longint frame_len;
    longint n;
    bit     fs_changed;
    while (items_sent < ItemTarget) begin
      fs_changed = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 19))
          0:       v = 0;
          1:       v = MaxFrameSamples;
          2:       v = 2047;
          3:       v = $urandom_range(1025, 2047);
          4:       v = $urandom_range(17, 200);
          default: v = $urandom_range(1, 16);
        endcase
        cfg_write(RegFrameSamples, with_junk(RegFrameSamples, v));
        fs_changed = 1'b1;
      end
      fs_eff = longint'(cur_frame_samples);
      if (fs_eff < 1) fs_eff = 1;
      if (fs_eff > longint'(MaxFrameSamples)) fs_eff = longint'(MaxFrameSamples);
      if (fs_changed || $urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 9))
          6:       v = 0;
          7:       v = 131071;
          8:       v = $urandom_range(0, 131071);
          9:       v = 1;
          default: v = DataW'((65536 + fs_eff / 2) / fs_eff);
        endcase
        cfg_write(RegFrameRecip, with_junk(RegFrameRecip, v));
      end
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0:       v = 0;
          1:       v = 15;
          2:       v = MaxChannels;
          3:       v = $urandom_range(9, 14);
          default: v = $urandom_range(1, 4);
        endcase
        cfg_write(RegChannelCount, with_junk(RegChannelCount, v));
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       v = DataW'(GainUnity);
          1:       v = 0;
          2:       v = DataW'(GainMax);
          3:       v = DataW'(prev_gain);
          4:       v = DataW'(GainW'(prev_gain + $urandom_range(0, 16) - 8));
          5, 6:    v = $urandom_range(0, GainMax);
          default: v = $urandom_range(0, 2 * GainUnity);
        endcase
        cfg_write(RegTargetGain, with_junk(RegTargetGain, v));
      end
      cc_eff = longint'(cur_channels);
      if (cc_eff < 1) cc_eff = 1;
      if (cc_eff > longint'(MaxChannels)) cc_eff = longint'(MaxChannels);
      frame_len = fs_eff * cc_eff;
      // whole frames plus up to two samples where they are short, a slice of the frame otherwise
      if (frame_len <= 64) n = frame_len * $urandom_range(1, 3) + $urandom_range(0, 2);
      else n = $urandom_range(5, 60);
      repeat (n) send_sample(pick_sample());
    end
  endtask

  // Receiver: check each beat, then pick the next tready from the stall pattern.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (scaled_fifo.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $error("sample_out: expected none, actual %0d", $signed(m_axis_tdata));
      end else begin
        want = scaled_fifo.pop_front();
        if (m_axis_tdata !== want.sample) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $error("sample_out: expected %0d, actual %0d",
                   $signed(want.sample), $signed(m_axis_tdata));
        end
        if (m_axis_tlast !== want.last) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $error("frame_end: expected %0b, actual %0b", want.last, m_axis_tlast);
        end
      end
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 4));
      rx_left = $urandom_range(8, 64);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RxOpen:      m_axis_tready <= 1'b1;
      RxCoin:      m_axis_tready <= 1'($urandom_range(0, 1));
      RxSparse:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      RxAlternate: m_axis_tready <= ~m_axis_tready;
      default:     m_axis_tready <= 1'b0;
    endcase
  end

  initial begin
    cur_target        = GainUnity;
    cur_frame_samples = FrameSamplesRst;
    cur_recip         = FrameRecipRst;
    cur_channels      = ChannelCountRst;
    prev_gain         = longint'(GainUnity);
    live_gain         = longint'(GainUnity);
    ramp_inc          = 0;
    sample_idx        = 0;
    channel_idx       = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unity_bypass();
    test_ramp_extremes();
    test_zero_step();
    test_length_limits();
    test_midframe_changes();
    test_random_traffic();

    drain_stream();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && scaled_fifo.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
